/* rtl/tksk_pkg.sv */
// tksk_pkg: sizes, codes and shared types of the top-k similarity keeper
// used by tksk_cell and top_k_similarity_keeper_unit; depends on nothing

package tksk_pkg;

	// store depth and field widths
	localparam int CAPACITY = 32;
	localparam int SCORE_W  = 17;
	localparam int ID_W     = 24;
	localparam int KEEP_W   = 6;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CMP_W    = (CNT_W > KEEP_W) ? CNT_W : KEEP_W;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_KEEP_COUNT     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SIMILARITY = 1'b1;

	// register reset values
	localparam logic [KEEP_W-1:0]  KEEP_COUNT_RST     = KEEP_W'(20);
	localparam logic [SCORE_W-1:0] MIN_SIMILARITY_RST = SCORE_W'(1);

	// input commands and result kinds
	localparam logic CMD_ADD     = 1'b0;
	localparam logic CMD_FLUSH   = 1'b1;
	localparam logic KIND_REPORT = 1'b0;
	localparam logic KIND_ENTRY  = 1'b1;

	// operation that every cell applies to its slot
	typedef enum logic [1:0] {
		OP_HOLD      = 2'd0,
		OP_INSERT    = 2'd1,
		OP_INS_EVICT = 2'd2,
		OP_SHIFT_UP  = 2'd3
	} cell_op_t;

	// one stored candidate
	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic [ID_W-1:0]    id;
	} entry_t;

	// control broadcast to the whole chain
	typedef struct packed {
		cell_op_t op;
		entry_t   item;
	} cell_ctl_t;

endpackage

/* rtl/top_k_similarity_keeper_unit.sv */
// top_k_similarity_keeper_unit: keeps the best scored candidates in a chain of cells
// depends on tksk_pkg and tksk_cell
//
//   channel   handshake               payload
//   input     start, busy             command, similarity, candidate_id, query_id
//   result    strobe (one cycle)      kind, query_id_out, entry_id, entry_score,
//                                     cutoff, last
//   config    cfg_we                  cfg_index, cfg_data
//
// an add: the ADD state does compare-and-shift over all cells, then the
// report sits in the output register while the next beat may already be taken
// a flush takes the accept cycle, then steps the chain up once a cycle and emits from
// the top cell once the stored entries reach it; with an empty store it emits nothing
// reset clears the state, count, cutoff, config registers and strobe; the cells are not cleared
// results cannot be stalled: each is shown for exactly one cycle

module top_k_similarity_keeper_unit import tksk_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 command,
	input  logic [SCORE_W-1:0]   similarity,
	input  logic [ID_W-1:0]      candidate_id,
	input  logic [ID_W-1:0]      query_id,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SCORE_W-1:0]   cfg_data,
	output logic                 strobe,
	output logic                 kind,
	output logic [ID_W-1:0]      query_id_out,
	output logic [ID_W-1:0]      entry_id,
	output logic [SCORE_W-1:0]   entry_score,
	output logic [SCORE_W-1:0]   cutoff,
	output logic                 last
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ADD   = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	logic [1:0]         state_q;
	logic [KEEP_W-1:0]  keep_q;
	logic [SCORE_W-1:0] min_sim_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   shift_q;
	logic [SCORE_W-1:0] cutoff_q;
	entry_t             item_q;
	logic [ID_W-1:0]    qid_q;

	logic               accept;
	cell_ctl_t          ctl;
	logic [CMP_W-1:0]   limit;
	logic               keep_it;
	logic               evict;
	logic               flush_emit;
	logic               flush_done;
	logic [SCORE_W-1:0] new_cutoff;

	entry_t cur_a [0:CAPACITY];
	logic   h_a   [0:CAPACITY];
	logic   live_a[0:CAPACITY-1];

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q    <= KEEP_COUNT_RST;
			min_sim_q <= MIN_SIMILARITY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEEP_COUNT:     keep_q    <= cfg_data[KEEP_W-1:0];
				REG_MIN_SIMILARITY: min_sim_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// keep limit clamped to 1..CAPACITY
	always_comb begin
		priority if (keep_q == '0)
			limit = CMP_W'(1);
		else if (CMP_W'(keep_q) > CMP_W'(CAPACITY))
			limit = CMP_W'(CAPACITY);
		else
			limit = CMP_W'(keep_q);
	end

	assign keep_it = (item_q.score >= min_sim_q);
	assign evict   = (CMP_W'(count_q) >= limit);

	// flush: top cell holds a stored entry once enough shifts have gone by
	assign flush_emit = (count_q != '0) && (shift_q >= (CNT_W'(CAPACITY) - count_q));
	assign flush_done = (count_q == '0) || (shift_q == CNT_W'(CAPACITY - 1));

	// chain operation for this cycle
	always_comb begin
		ctl.item = item_q;
		unique case (state_q)
			ST_ADD:   ctl.op = keep_it ? (evict ? OP_INS_EVICT : OP_INSERT) : OP_HOLD;
			ST_FLUSH: ctl.op = OP_SHIFT_UP;
			default:  ctl.op = OP_HOLD;
		endcase
	end

	// chain ends: above the top is always an empty slot
	assign cur_a[CAPACITY] = '0;
	assign h_a[CAPACITY]   = 1'b1;

	// row of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		entry_t lo_e;
		logic   lo_hv;

		assign live_a[i] = (CNT_W'(i) < count_q);
		if (i == 0) begin : g_bottom
			assign lo_e  = '0;
			assign lo_hv = 1'b0;
		end else begin : g_inner
			assign lo_e  = cur_a[i-1];
			assign lo_hv = h_a[i-1];
		end

		tksk_cell u_cell (
			.clk  (clk),
			.ctl  (ctl),
			.live (live_a[i]),
			.lo   (lo_e),
			.lo_h (lo_hv),
			.hi   (cur_a[i+1]),
			.hi_h (h_a[i+1]),
			.cur  (cur_a[i]),
			.h    (h_a[i])
		);
	end

	// smallest score left after insert and evict
	assign new_cutoff = h_a[0] ? cur_a[0].score : (h_a[1] ? item_q.score : cur_a[1].score);

	// sequencer, count and cutoff
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			shift_q  <= '0;
			cutoff_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					shift_q <= '0;
					if (accept)
						state_q <= (command == CMD_FLUSH) ? ST_FLUSH : ST_ADD;
				end
				ST_ADD: begin
					state_q <= ST_IDLE;
					if (keep_it) begin
						if (evict)
							cutoff_q <= new_cutoff;
						else
							count_q <= count_q + CNT_W'(1);
					end
				end
				ST_FLUSH: begin
					shift_q <= shift_q + CNT_W'(1);
					if (flush_done) begin
						state_q  <= ST_IDLE;
						count_q  <= '0;
						cutoff_q <= '0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// input item register
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q.score <= similarity;
			item_q.id    <= candidate_id;
			qid_q        <= query_id;
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			strobe <= 1'b0;
		else
			strobe <= (state_q == ST_ADD) || ((state_q == ST_FLUSH) && flush_emit);
	end

	// result beat register
	always_ff @(posedge clk) begin
		if (state_q == ST_ADD) begin
			kind         <= KIND_REPORT;
			query_id_out <= '0;
			entry_id     <= '0;
			entry_score  <= '0;
			cutoff       <= (keep_it && evict) ? new_cutoff : cutoff_q;
			last         <= 1'b1;
		end else if (state_q == ST_FLUSH && flush_emit) begin
			kind         <= KIND_ENTRY;
			query_id_out <= qid_q;
			entry_id     <= cur_a[CAPACITY-1].id;
			entry_score  <= cur_a[CAPACITY-1].score;
			cutoff       <= cutoff_q;
			last         <= flush_done;
		end
	end

	// an accepted add is reported after the ADD state, from the result register
	a_add_report: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && command == CMD_ADD) |-> ##2 (strobe && last && kind == KIND_REPORT))
		else $error("add beat not reported");

	// the store never holds more than its depth
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(count_q) <= CMP_W'(CAPACITY))
		else $error("entry count beyond capacity");

	// the final list entry leaves an empty store with a cleared cutoff
	a_flush_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last && kind == KIND_ENTRY) |-> (count_q == '0 && cutoff_q == '0))
		else $error("store not cleared after flush");

	// a taken item always makes the block busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not start work");

endmodule

/* rtl/tksk_cell.sv */
// tksk_cell: one slot of the sorted candidate chain
// holds one entry, trades it with its neighbors; depends on tksk_pkg

module tksk_cell import tksk_pkg::*; (
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  logic      live,
	input  entry_t    lo,
	input  logic      lo_h,
	input  entry_t    hi,
	input  logic      hi_h,
	output entry_t    cur,
	output logic      h
);

	entry_t slot_q;
	entry_t slot_d;

	// empty slot or stored score above the new one
	assign h   = !live || (slot_q.score > ctl.item.score);
	assign cur = slot_q;

	// next slot content from the chain operation
	always_comb begin
		unique case (ctl.op)
			OP_INSERT:    slot_d = lo_h ? lo : (h ? ctl.item : slot_q);
			OP_INS_EVICT: slot_d = h ? slot_q : (hi_h ? ctl.item : hi);
			OP_SHIFT_UP:  slot_d = lo;
			default:      slot_d = slot_q;
		endcase
	end

	always_ff @(posedge clk) begin
		slot_q <= slot_d;
	end

endmodule

/* dv/top_k_similarity_keeper_unit_tb.sv */
// top_k_similarity_keeper_unit_tb: self-checking bench for the top-k similarity keeper
// a queue-fed driver, a result monitor and a score-ordered store predictor
// depends on tksk_pkg and top_k_similarity_keeper_unit

module top_k_similarity_keeper_unit_tb import tksk_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF     = 4;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES  = 40;
	localparam int LIMIT_CYCLES = 200000;
	localparam int RAND_ITEMS   = 200;
	localparam int PRINT_CAP    = 100;

	typedef enum logic [1:0] {
		STEP_ITEM,
		STEP_CFG,
		STEP_PAUSE
	} step_kind_t;

	// one pending stimulus step: an input beat, a register write or a pause
	typedef struct {
		step_kind_t           what;
		logic                 command;
		logic [SCORE_W-1:0]   similarity;
		logic [ID_W-1:0]      candidate_id;
		logic [ID_W-1:0]      query_id;
		logic [CFG_IDX_W-1:0] index;
		logic [SCORE_W-1:0]   data;
	} step_t;

	// one result beat
	typedef struct {
		logic               kind;
		logic [ID_W-1:0]    query_id;
		logic [ID_W-1:0]    entry_id;
		logic [SCORE_W-1:0] score;
		logic [SCORE_W-1:0] cutoff;
		logic               last;
	} out_beat_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic                 command = CMD_ADD;
	logic [SCORE_W-1:0]   similarity = '0;
	logic [ID_W-1:0]      candidate_id = '0;
	logic [ID_W-1:0]      query_id = '0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_KEEP_COUNT;
	logic [SCORE_W-1:0]   cfg_data = '0;
	logic                 strobe;
	logic                 kind;
	logic [ID_W-1:0]      query_id_out;
	logic [ID_W-1:0]      entry_id;
	logic [SCORE_W-1:0]   entry_score;
	logic [SCORE_W-1:0]   cutoff;
	logic                 last;

	top_k_similarity_keeper_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.similarity   (similarity),
		.candidate_id (candidate_id),
		.query_id     (query_id),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.strobe       (strobe),
		.kind         (kind),
		.query_id_out (query_id_out),
		.entry_id     (entry_id),
		.entry_score  (entry_score),
		.cutoff       (cutoff),
		.last         (last)
	);

	// clock and reset
	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
	end

	// shadow of the sorted candidate store and its registers
	logic [SCORE_W-1:0] kept_score [CAPACITY+1];
	logic [ID_W-1:0]    kept_id    [CAPACITY+1];
	int                 kept_cnt = 0;
	logic [SCORE_W-1:0] kept_cutoff = '0;
	logic [KEEP_W-1:0]  keep_reg = KEEP_COUNT_RST;
	logic [SCORE_W-1:0] min_reg = MIN_SIMILARITY_RST;

	out_beat_t want_q[$];
	step_t     stim_q[$];
	int        pred_cnt = 0;
	int        seen_cnt = 0;
	int        err_cnt = 0;
	int        cycle_cnt = 0;

	// effective keep limit, clamped to 1..CAPACITY
	function automatic int keep_limit();
		int k;
		k = keep_reg;
		if (k < 1) k = 1;
		if (k > CAPACITY) k = CAPACITY;
		return k;
	endfunction

	// add: ordered insert after equal scores, evict the oldest smallest on overflow
	function automatic int rank_add(logic [SCORE_W-1:0] score, logic [ID_W-1:0] id);
		int        pos;
		out_beat_t b;
		if (score >= min_reg) begin
			if (kept_cnt > CAPACITY) kept_cnt = CAPACITY;
			pos = kept_cnt;
			while (pos > 0 && kept_score[pos-1] > score) begin
				kept_score[pos] = kept_score[pos-1];
				kept_id[pos] = kept_id[pos-1];
				pos--;
			end
			kept_score[pos] = score;
			kept_id[pos] = id;
			kept_cnt++;
			if (kept_cnt > keep_limit()) begin
				for (int i = 1; i < kept_cnt; i++) begin
					kept_score[i-1] = kept_score[i];
					kept_id[i-1] = kept_id[i];
				end
				kept_cnt--;
				kept_cutoff = kept_score[0];
			end
		end
		b.kind = KIND_REPORT;
		b.query_id = '0;
		b.entry_id = '0;
		b.score = '0;
		b.cutoff = kept_cutoff;
		b.last = 1'b1;
		want_q.insert(want_q.size(), b);
		return 1;
	endfunction

	// flush: list largest first with the old cutoff, then clear
	function automatic int rank_flush(logic [ID_W-1:0] qid);
		int        n;
		out_beat_t b;
		n = 0;
		for (int i = kept_cnt - 1; i >= 0; i--) begin
			b.kind = KIND_ENTRY;
			b.query_id = qid;
			b.entry_id = kept_id[i];
			b.score = kept_score[i];
			b.cutoff = kept_cutoff;
			b.last = (i == 0);
			want_q.insert(want_q.size(), b);
			n++;
		end
		kept_cnt = 0;
		kept_cutoff = '0;
		return n;
	endfunction

	// stimulus queue helpers
	function automatic void push_add(logic [SCORE_W-1:0] sim, logic [ID_W-1:0] cid,
			logic [ID_W-1:0] qid);
		step_t s;
		s.what = STEP_ITEM;
		s.command = CMD_ADD;
		s.similarity = sim;
		s.candidate_id = cid;
		s.query_id = qid;
		s.index = REG_KEEP_COUNT;
		s.data = '0;
		stim_q.insert(stim_q.size(), s);
	endfunction

	function automatic void push_flush(logic [ID_W-1:0] qid);
		step_t s;
		s.what = STEP_ITEM;
		s.command = CMD_FLUSH;
		s.similarity = SCORE_W'($urandom);
		s.candidate_id = ID_W'($urandom);
		s.query_id = qid;
		s.index = REG_KEEP_COUNT;
		s.data = '0;
		stim_q.insert(stim_q.size(), s);
	endfunction

	function automatic void push_cfg(logic [CFG_IDX_W-1:0] idx, logic [SCORE_W-1:0] data);
		step_t s;
		s.what = STEP_CFG;
		s.command = CMD_ADD;
		s.similarity = '0;
		s.candidate_id = '0;
		s.query_id = '0;
		s.index = idx;
		s.data = data;
		stim_q.insert(stim_q.size(), s);
	endfunction

	function automatic void push_pause();
		step_t s;
		s.what = STEP_PAUSE;
		s.command = CMD_ADD;
		s.similarity = '0;
		s.candidate_id = '0;
		s.query_id = '0;
		s.index = REG_KEEP_COUNT;
		s.data = '0;
		stim_q.insert(stim_q.size(), s);
	endfunction

	// scores: a coarse grid for ties, the full Q1.16 range up to 1.0, raw 17-bit values, edges
	function automatic logic [SCORE_W-1:0] rand_score();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return SCORE_W'($urandom_range(0, 15) * 4096);
			8: return SCORE_W'($urandom_range(0, 17'h1FFFF));
			9: begin
				case ($urandom_range(0, 3))
					0: return '0;
					1: return SCORE_W'(1);
					2: return SCORE_W'(65536);
					default: return SCORE_W'(17'h1FFFF);
				endcase
			end
			default: return SCORE_W'($urandom_range(0, 65536));
		endcase
	endfunction

	function automatic logic [SCORE_W-1:0] rand_threshold();
		case ($urandom_range(0, 9))
			6: return '0;
			7: return SCORE_W'(65536);
			8: return SCORE_W'($urandom_range(0, 17'h1FFFF));
			9: return SCORE_W'(1);
			default: return SCORE_W'($urandom_range(0, 4096));
		endcase
	endfunction

	// keep count with junk in the unused upper bits
	function automatic logic [SCORE_W-1:0] rand_keep();
		logic [SCORE_W-1:0] data;
		logic [KEEP_W-1:0]  k;
		case ($urandom_range(0, 9))
			0: k = '0;
			1: k = KEEP_W'($urandom_range(33, 63));
			2: k = KEEP_W'(CAPACITY);
			3: k = KEEP_W'(1);
			default: k = KEEP_W'($urandom_range(1, 32));
		endcase
		data = SCORE_W'($urandom);
		data[KEEP_W-1:0] = k;
		return data;
	endfunction

	// driver: bursts of beats with random gaps, register writes only when idle
	int burst_left = 1;
	int gap_left = 0;
	int settle_cnt = 0;

	always @(posedge clk or negedge arst_n) begin
		step_t s;
		logic  take;
		logic  go;
		logic  wr;
		int    n;
		if (!arst_n) begin
			start <= 1'b0;
			cfg_we <= 1'b0;
			pred_cnt <= 0;
			burst_left = $urandom_range(1, 24);
			gap_left = 0;
			settle_cnt = 0;
		end else begin
			take = start && !busy;
			go = start && busy;
			wr = 1'b0;
			n = 0;
			if (take) begin
				if (command == CMD_ADD) n = rank_add(similarity, candidate_id);
				else n = rank_flush(query_id);
			end
			pred_cnt <= pred_cnt + n;

			// quiet cycles since the last expected result
			if (!start && !busy && pred_cnt == seen_cnt) settle_cnt++;
			else settle_cnt = 0;

			if (go) begin
				// beat still offered
			end else if (gap_left > 0) begin
				gap_left--;
			end else if (stim_q.size() != 0) begin
				s = stim_q[0];
				if (s.what == STEP_ITEM) begin
					void'(stim_q.pop_front());
					go = 1'b1;
					command <= s.command;
					similarity <= s.similarity;
					candidate_id <= s.candidate_id;
					query_id <= s.query_id;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
					end
				end else if (settle_cnt >= SETTLE_CYCLES) begin
					void'(stim_q.pop_front());
					settle_cnt = 0;
					if (s.what == STEP_CFG) begin
						wr = 1'b1;
						cfg_index <= s.index;
						cfg_data <= s.data;
						if (s.index == REG_KEEP_COUNT) keep_reg = s.data[KEEP_W-1:0];
						else min_reg = s.data;
					end
				end
			end
			start <= go;
			cfg_we <= wr;
		end
	end

	// one line per mismatch up to PRINT_CAP, counted always
	task automatic report_miss(string what, logic [31:0] got, logic [31:0] exp);
		if (err_cnt < PRINT_CAP)
			$display("mismatch at %0t, beat %0d: %s got 0x%0h want 0x%0h",
				$time, seen_cnt, what, got, exp);
		err_cnt++;
	endtask

	// monitor: every strobe is checked against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		out_beat_t w;
		if (!arst_n) begin
			seen_cnt <= 0;
		end else if (strobe) begin
			if (seen_cnt >= pred_cnt) begin
				report_miss("beat with nothing expected", 32'(kind), 32'(last));
			end else begin
				w = want_q.pop_front();
				if (kind !== w.kind) report_miss("kind", 32'(kind), 32'(w.kind));
				if (query_id_out !== w.query_id)
					report_miss("query_id_out", 32'(query_id_out), 32'(w.query_id));
				if (entry_id !== w.entry_id)
					report_miss("entry_id", 32'(entry_id), 32'(w.entry_id));
				if (entry_score !== w.score)
					report_miss("entry_score", 32'(entry_score), 32'(w.score));
				if (cutoff !== w.cutoff) report_miss("cutoff", 32'(cutoff), 32'(w.cutoff));
				if (last !== w.last) report_miss("last", 32'(last), 32'(w.last));
				seen_cnt <= seen_cnt + 1;
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= LIMIT_CYCLES) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// stimulus and end of test
	initial begin
		int added;
		int phase_len;

		// reset settings: keep 20, floor 1
		push_add('0, 24'hFFFFFF, 24'hFFFFFF);           // below the floor, dropped
		push_add(SCORE_W'(65536), 24'hFFFFFF, 24'h000001);
		push_add(SCORE_W'(17'h1FFFF), 24'h000000, 24'h000002); // above 1.0
		push_add(SCORE_W'(1), 24'h123456, 24'h000003);  // exactly the floor
		push_add(SCORE_W'(300), 24'h0000A1, 24'h000004);
		push_add(SCORE_W'(300), 24'h0000A2, 24'h000005); // tie goes after
		push_flush(24'hFFFFFF);
		push_flush(24'h000000);                         // empty store, no beats

		// keep of zero acts as one, floor off: ties evict the oldest
		push_cfg(REG_KEEP_COUNT, SCORE_W'(17'h1FFC0));
		push_cfg(REG_MIN_SIMILARITY, '0);
		push_add('0, 24'h000001, 24'h0);
		push_add(SCORE_W'(5), 24'h000002, 24'h0);
		push_add(SCORE_W'(5), 24'h000003, 24'h0);
		push_add(SCORE_W'(3), 24'h000004, 24'h0);        // smaller than all, evicted at once
		push_flush(24'h5A5A5A);

		// oversized keep clamps, then a lower keep with more entries stored
		push_cfg(REG_KEEP_COUNT, SCORE_W'(63));
		for (int i = 0; i < 6; i++) push_add(rand_score(), ID_W'($urandom), ID_W'($urandom));
		push_pause();
		push_cfg(REG_KEEP_COUNT, SCORE_W'(2));
		push_cfg(REG_MIN_SIMILARITY, SCORE_W'(65536));
		push_add(SCORE_W'(65536), 24'hABCDEF, 24'h0);
		push_add(SCORE_W'(17'h1FFFF), 24'h654321, 24'h0);
		push_add(SCORE_W'(65535), 24'h777777, 24'h0);   // dropped, cutoff still reported
		push_flush(24'hA5A5A5);

		// random phases: new settings, then a run of adds with occasional flushes
		added = 0;
		while (added < RAND_ITEMS) begin
			if ($urandom_range(0, 3) != 0) push_cfg(REG_KEEP_COUNT, rand_keep());
			if ($urandom_range(0, 2) != 0) push_cfg(REG_MIN_SIMILARITY, rand_threshold());
			phase_len = $urandom_range(8, 40);
			for (int i = 0; i < phase_len; i++) begin
				if ($urandom_range(0, 13) == 0) push_flush(ID_W'($urandom));
				else push_add(rand_score(), ID_W'($urandom), ID_W'($urandom));
				if ($urandom_range(0, 29) == 0) push_pause();
				added++;
			end
		end
		push_flush(ID_W'($urandom));

		@(posedge arst_n);
		do @(negedge clk);
		while (stim_q.size() != 0 || start || busy || pred_cnt != seen_cnt);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (want_q.size() != 0)
			report_miss("expected beats never seen", 32'(want_q.size()), 32'd0);

		if (err_cnt == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
